// File: src/tlfsr_pkg.sv
package tlfsr_pkg;

    // Register widths
    localparam int W_FIRST  = 41;
    localparam int W_SECOND = 43;
    localparam int W_THIRD  = 47;
    localparam int W_CFG    = 47;
    localparam int W_INDEX  = 2;
    localparam int W_BYTE   = 8;
    localparam int N_TABLES = 3;

    // Feedback tap masks
    localparam logic [W_FIRST-1:0]  TAPS_FIRST  = 41'h100_0000_0016;
    localparam logic [W_SECOND-1:0] TAPS_SECOND = 43'h400_0000_1995;
    localparam logic [W_THIRD-1:0]  TAPS_THIRD  = 47'h4000_0000_0034;

    // Combining functions, indexed by {third[0], second[0], first[0]}
    localparam logic [7:0] COMBINE_TABLES [N_TABLES] = '{8'hE8, 8'hD2, 8'hCA};

    // Configuration register indexes
    localparam logic [W_INDEX-1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [W_INDEX-1:0] REG_KEY_SECOND = 2'd1;
    localparam logic [W_INDEX-1:0] REG_KEY_THIRD  = 2'd2;

    typedef struct packed {
        logic [W_BYTE-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic [W_BYTE-1:0] result_byte;
        logic              message_end;
    } out_item_t;

    typedef struct packed {
        logic [W_FIRST-1:0]  first;
        logic [W_SECOND-1:0] second;
        logic [W_THIRD-1:0]  third;
    } key_set_t;

endpackage

// File: src/tlfsr_keys.sv
module tlfsr_keys (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tlfsr_pkg::W_INDEX-1:0] cfg_index,
    input  logic [tlfsr_pkg::W_CFG-1:0]   cfg_wdata,
    output tlfsr_pkg::key_set_t           keys
);

    tlfsr_pkg::key_set_t keys_reg;
    tlfsr_pkg::key_set_t keys_next;

    // Decode the write; indexes beyond the key list are dropped
    always_comb begin
        keys_next = keys_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                tlfsr_pkg::REG_KEY_FIRST:
                    keys_next.first  = cfg_wdata[tlfsr_pkg::W_FIRST-1:0];
                tlfsr_pkg::REG_KEY_SECOND:
                    keys_next.second = cfg_wdata[tlfsr_pkg::W_SECOND-1:0];
                tlfsr_pkg::REG_KEY_THIRD:
                    keys_next.third  = cfg_wdata[tlfsr_pkg::W_THIRD-1:0];
                default: keys_next = keys_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_reg <= '0;
        end else begin
            keys_reg <= keys_next;
        end
    end

    assign keys = keys_reg;

endmodule

// File: src/tlfsr_queue.sv
module tlfsr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlfsr_pkg::in_item_t s_data,
    output logic                q_valid,
    input  logic                q_pop,
    output tlfsr_pkg::in_item_t q_data
);

    tlfsr_pkg::in_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_data;
        end
    end

endmodule

// File: src/tlfsr_engine.sv
module tlfsr_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tlfsr_pkg::key_set_t  keys,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  tlfsr_pkg::in_item_t  q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tlfsr_pkg::out_item_t m_data
);

    logic [tlfsr_pkg::W_FIRST-1:0]  first_reg, first_next, first_adv;
    logic [tlfsr_pkg::W_SECOND-1:0] second_reg, second_next, second_adv;
    logic [tlfsr_pkg::W_THIRD-1:0]  third_reg, third_next, third_adv;
    logic [tlfsr_pkg::W_BYTE-1:0]   keystream;
    logic [2:0]                     sel;
    logic                           m_valid_reg, m_valid_next;
    tlfsr_pkg::out_item_t           m_data_reg;

    // Take the next request whenever the output register is free
    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    // Eight register steps, one keystream bit each
    always_comb begin
        first_adv  = first_reg;
        second_adv = second_reg;
        third_adv  = third_reg;
        sel        = 3'd0;
        keystream  = '0;
        for (int j = 0; j < tlfsr_pkg::W_BYTE; j++) begin
            sel = {third_adv[0], second_adv[0], first_adv[0]};
            keystream[j] = tlfsr_pkg::COMBINE_TABLES[j % tlfsr_pkg::N_TABLES][sel];
            first_adv  = {^(first_adv & tlfsr_pkg::TAPS_FIRST),
                          first_adv[tlfsr_pkg::W_FIRST-1:1]};
            second_adv = {^(second_adv & tlfsr_pkg::TAPS_SECOND),
                          second_adv[tlfsr_pkg::W_SECOND-1:1]};
            third_adv  = {^(third_adv & tlfsr_pkg::TAPS_THIRD),
                          third_adv[tlfsr_pkg::W_THIRD-1:1]};
        end
    end

    // Advance the registers, or reload the keys after the last byte
    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        third_next  = third_reg;
        if (q_pop) begin
            if (q_data.last_byte) begin
                first_next  = keys.first;
                second_next = keys.second;
                third_next  = keys.third;
            end else begin
                first_next  = first_adv;
                second_next = second_adv;
                third_next  = third_adv;
            end
        end
    end

    // Hold the result until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg   <= '0;
            second_reg  <= '0;
            third_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            first_reg   <= first_next;
            second_reg  <= second_next;
            third_reg   <= third_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_data_reg.result_byte <= q_data.data_byte ^ keystream;
            m_data_reg.message_end <= q_data.last_byte;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/three_lfsr_filtered_stream_cipher.sv
// Three-register filtered stream cipher, one byte per request.
//
// Input channel s_*: one plaintext or ciphertext byte per request, with a
// flag marking the last byte of a message. Output channel m_*: the byte
// XOR eight keystream bits, and the end-of-message flag copied through.
// The cfg_* port writes the three key registers (index 0, 1, 2); other
// indexes are ignored. A new key takes effect at the next reload, which
// follows every byte marked last.
//
// A request accepted on s_* is stored in the queue, then registered in the
// engine's output register. Throughput: one byte per cycle while m_ready
// is high; the engine does a byte's eight keystream steps combinationally.
// A two-entry queue sits between the input side and the engine, and the
// engine's output register holds a result while the receiver stalls; the
// input keeps accepting until the queue is full.
// Reset clears the keys and the shift registers to zero and empties the
// queue and output register.
module three_lfsr_filtered_stream_cipher (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tlfsr_pkg::W_INDEX-1:0] cfg_index,
    input  logic [tlfsr_pkg::W_CFG-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  tlfsr_pkg::in_item_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output tlfsr_pkg::out_item_t          m_data
);

    tlfsr_pkg::key_set_t keys;
    tlfsr_pkg::in_item_t q_data;
    logic                q_valid;
    logic                q_pop;

    tlfsr_keys u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .keys      (keys)
    );

    tlfsr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    tlfsr_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .keys    (keys),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: src/tlfsr_checker.sv
module tlfsr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input tlfsr_pkg::out_item_t          m_data
);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A full queue means the output register is waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with output empty");

    // The queue only fills on an accepted request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("queue filled without a request");

endmodule

bind three_lfsr_filtered_stream_cipher tlfsr_checker u_checker (.*);
